// ----- sv/masked_template_window_score_macros.svh -----
// assertion macros shared by the checker of the window scorer
// depends on: a clk and an rst signal in the scope that uses them
`ifndef MASKED_TEMPLATE_WINDOW_SCORE_MACROS_SVH
`define MASKED_TEMPLATE_WINDOW_SCORE_MACROS_SVH

// antecedent and consequent in the same cycle
`define MTWS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define MTWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/mtws_pkg.sv -----
// shared types and constants of the masked template window scorer
// no dependencies; used by every module of the block
`default_nettype none

package mtws_pkg;

  localparam int MAX_WINDOW_PIXELS_DEF = 4096;
  localparam int CH_W       = 8;
  localparam int COORD_W    = 12;
  localparam int NET_W      = 14;
  localparam int PCT_W      = 7;
  localparam int TOL_W      = 8;
  localparam int CFG_DATA_W = 8;
  localparam int S_TDATA_W  = 72;
  localparam int M_TDATA_W  = 64;
  localparam int Q_DEPTH    = 2;

  localparam logic [PCT_W-1:0] PCT_RESET = 7'd75;
  localparam logic [TOL_W-1:0] TOL_RESET = 8'd32;

  typedef enum logic [0:0] {
    CFG_MATCH_PERCENT   = 1'b0,
    CFG_PIXEL_TOLERANCE = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  // one stored pixel with its background mark
  typedef struct packed {
    logic   black;
    pixel_t px;
  } mem_word_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic                    is_match;
    logic signed [NET_W-1:0] net_score;
    logic [CH_W-1:0]         avg_red;
    logic [CH_W-1:0]         avg_green;
    logic [CH_W-1:0]         avg_blue;
    logic                    no_background;
    logic [COORD_W-1:0]      match_row;
    logic [COORD_W-1:0]      match_col;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/masked_template_window_score.sv -----
// Masked template window scorer, top level.
//
// Input stream s_axis: one word per window pixel in row-major order, image
// pixel, mask pixel and window corner; tlast marks the final pixel of a window.
// Output stream m_axis: one word per window with the match flag, net score,
// background averages, no-background flag and the echoed corner.
// Config: cfg_we/cfg_index/cfg_data write match_percent (index 0) and
// pixel_tolerance (index 1); write them only while no window is in flight.
//
// Each pixel is written into the pixel memory as it loads and is read once by the
// comparison scan. After tlast the result is built from the queue hand-over,
// eight divide steps for the averages, the scan of the stored pixels and two
// threshold steps; a window with no background skips the divide and the scan.
// s_axis_tready drops after tlast until the scan has finished with the memory;
// the next window then loads while the result waits in the output register.
// A stalled receiver holds the result; a second finished window waits in the
// back until the register frees. Reset (rst, synchronous) empties everything and
// restores match_percent = 75, pixel_tolerance = 32; no memory clearing is needed.
// depends on: mtws_pkg, mtws_front, mtws_queue, mtws_back
`default_nettype none

module masked_template_window_score #(
  parameter int MAX_WINDOW_PIXELS = mtws_pkg::MAX_WINDOW_PIXELS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // img_red, img_green, img_blue, mask_red, mask_green, mask_blue,
  // window_row, window_col
  input  wire logic [mtws_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  input  wire logic                                s_axis_tlast,    // last_pixel
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // is_match, net_score, avg_red, avg_green, avg_blue, no_background,
  // match_row, match_col
  output logic [mtws_pkg::M_TDATA_W-1:0]           m_axis_tdata,
  input  wire logic                                cfg_we,
  input  wire logic [0:0]                          cfg_index,
  input  wire logic [mtws_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW    = $clog2(MAX_WINDOW_PIXELS + 1);
  localparam int SW    = CW + mtws_pkg::CH_W;
  localparam int AW    = (MAX_WINDOW_PIXELS > 1) ? $clog2(MAX_WINDOW_PIXELS) : 1;
  localparam int JOB_W = 2*mtws_pkg::COORD_W + 2*CW + 3*SW;

  logic [mtws_pkg::PCT_W-1:0]   match_percent;
  logic [mtws_pkg::TOL_W-1:0]   pixel_tolerance;
  mtws_pkg::pixel_t             img, mask;
  logic [mtws_pkg::COORD_W-1:0] win_row, win_col;
  mtws_pkg::q_status_t          q_stat;
  logic                         q_push, q_pop, mem_release;
  logic [JOB_W-1:0]             q_wdata, q_rdata;
  logic [AW-1:0]                rd_addr;
  mtws_pkg::mem_word_t          rd_data;
  mtws_pkg::result_t            result;

  assign {win_col, win_row, mask.blue, mask.green, mask.red,
          img.blue, img.green, img.red} = s_axis_tdata;

  assign m_axis_tdata = {result.match_col, result.match_row, result.no_background,
                         result.avg_blue, result.avg_green, result.avg_red,
                         result.net_score, result.is_match};

  always_ff @(posedge clk) begin
    if (rst) begin
      match_percent   <= mtws_pkg::PCT_RESET;
      pixel_tolerance <= mtws_pkg::TOL_RESET;
    end else if (cfg_we) begin
      unique case (mtws_pkg::cfg_index_t'(cfg_index))
        mtws_pkg::CFG_MATCH_PERCENT:   match_percent   <= cfg_data[mtws_pkg::PCT_W-1:0];
        mtws_pkg::CFG_PIXEL_TOLERANCE: pixel_tolerance <= cfg_data[mtws_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  mtws_front #(
    .MAX_WINDOW_PIXELS(MAX_WINDOW_PIXELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .img        (img),
    .mask       (mask),
    .row        (win_row),
    .col        (win_col),
    .last       (s_axis_tlast),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_wdata    (q_wdata),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .mem_release(mem_release)
  );

  mtws_queue #(
    .WIDTH(JOB_W)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .stat (q_stat)
  );

  mtws_back #(
    .MAX_WINDOW_PIXELS(MAX_WINDOW_PIXELS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_stat     (q_stat),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .mem_release(mem_release),
    .pct        (match_percent),
    .tol        (pixel_tolerance),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .result     (result)
  );

endmodule

`default_nettype wire

// ----- sv/mtws_queue.sv -----
// short queue of window jobs between the front and the back
// depends on: mtws_pkg
`default_nettype none

module mtws_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire logic [WIDTH-1:0]   wdata,
  input  wire logic               pop,
  output logic [WIDTH-1:0]        rdata,
  output mtws_pkg::q_status_t     stat
);

  localparam int DEPTH = mtws_pkg::Q_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign do_push    = push && (count != NW'(DEPTH));
  assign do_pop     = pop && (count != '0);
  assign rdata      = entries[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == NW'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + NW'(do_push) - NW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- sv/mtws_divider.sv -----
// shared restoring divider: three colour sums over one pixel count, eight steps
// depends on: mtws_pkg
`default_nettype none

module mtws_divider #(
  parameter int MAX_WINDOW_PIXELS = mtws_pkg::MAX_WINDOW_PIXELS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic [2:0][$clog2(MAX_WINDOW_PIXELS+1)+mtws_pkg::CH_W-1:0] sums,
  input  wire logic [$clog2(MAX_WINDOW_PIXELS+1)-1:0] divisor,
  output logic                                        done,
  output logic [2:0][mtws_pkg::CH_W-1:0]              quot
);

  localparam int CW = $clog2(MAX_WINDOW_PIXELS + 1);
  localparam int SW = CW + mtws_pkg::CH_W;

  logic          busy;
  logic [2:0]    step;
  logic [SW-1:0] dshift;
  logic [SW-1:0] rem [3];

  // the average never exceeds 255, so eight quotient bits are enough
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == '0);
      if (start) begin
        busy   <= 1'b1;
        step   <= 3'd7;
        dshift <= {1'b0, divisor, 7'd0};
      end else if (busy) begin
        dshift <= dshift >> 1;
        step   <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      if (start) begin
        rem[l]  <= sums[l];
        quot[l] <= '0;
      end else if (busy) begin
        if (rem[l] >= dshift) begin
          rem[l]  <= rem[l] - dshift;
          quot[l] <= {quot[l][mtws_pkg::CH_W-2:0], 1'b1};
        end else begin
          quot[l] <= {quot[l][mtws_pkg::CH_W-2:0], 1'b0};
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/mtws_front.sv -----
// front: takes window pixels, stores them, sums the background and queues a job
// depends on: mtws_pkg; holds the pixel memory read by the back
`default_nettype none

module mtws_front #(
  parameter int MAX_WINDOW_PIXELS = mtws_pkg::MAX_WINDOW_PIXELS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire mtws_pkg::pixel_t                  img,
  input  wire mtws_pkg::pixel_t                  mask,
  input  wire logic [mtws_pkg::COORD_W-1:0]      row,
  input  wire logic [mtws_pkg::COORD_W-1:0]      col,
  input  wire logic                              last,
  input  wire mtws_pkg::q_status_t               q_stat,
  output logic                                   q_push,
  output logic [2*mtws_pkg::COORD_W + 5*$clog2(MAX_WINDOW_PIXELS+1)
                + 3*mtws_pkg::CH_W - 1:0]        q_wdata,
  input  wire logic [((MAX_WINDOW_PIXELS > 1) ? $clog2(MAX_WINDOW_PIXELS) : 1)-1:0] rd_addr,
  output mtws_pkg::mem_word_t                    rd_data,
  input  wire logic                              mem_release
);

  localparam int CW = $clog2(MAX_WINDOW_PIXELS + 1);
  localparam int SW = CW + mtws_pkg::CH_W;
  localparam int AW = (MAX_WINDOW_PIXELS > 1) ? $clog2(MAX_WINDOW_PIXELS) : 1;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_WINDOW_PIXELS);

  typedef enum logic {F_LOAD, F_WAIT} front_state_t;

  front_state_t        state;
  logic [SW-1:0]       sum_red, sum_green, sum_blue;
  logic [SW-1:0]       sum_red_next, sum_green_next, sum_blue_next;
  logic [CW-1:0]       black_count, pixel_count;
  logic [CW-1:0]       black_count_next, pixel_count_next;
  logic                accept, black, room, take_bg;
  mtws_pkg::mem_word_t mem [MAX_WINDOW_PIXELS];

  assign in_ready = (state == F_LOAD) && !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign black    = (mask.red | mask.green | mask.blue) == '0;
  // words past the window limit are dropped but still close the window
  assign room     = (pixel_count != MAX_C);
  assign take_bg  = room && black;

  always_comb begin
    sum_red_next     = sum_red   + (take_bg ? {{CW{1'b0}}, img.red}   : '0);
    sum_green_next   = sum_green + (take_bg ? {{CW{1'b0}}, img.green} : '0);
    sum_blue_next    = sum_blue  + (take_bg ? {{CW{1'b0}}, img.blue}  : '0);
    black_count_next = black_count + CW'(take_bg);
    pixel_count_next = pixel_count + CW'(room);
  end

  assign q_push  = accept && last;
  assign q_wdata = {row, col, pixel_count_next, black_count_next,
                    sum_blue_next, sum_green_next, sum_red_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_LOAD;
      sum_red     <= '0;
      sum_green   <= '0;
      sum_blue    <= '0;
      black_count <= '0;
      pixel_count <= '0;
    end else begin
      unique case (state)
        F_LOAD: begin
          if (accept) begin
            if (last) begin
              sum_red     <= '0;
              sum_green   <= '0;
              sum_blue    <= '0;
              black_count <= '0;
              pixel_count <= '0;
              state       <= F_WAIT;
            end else begin
              sum_red     <= sum_red_next;
              sum_green   <= sum_green_next;
              sum_blue    <= sum_blue_next;
              black_count <= black_count_next;
              pixel_count <= pixel_count_next;
            end
          end
        end
        // memory belongs to the back until its scan is over
        F_WAIT: begin
          if (mem_release) begin
            state <= F_LOAD;
          end
        end
        default: state <= F_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && room) begin
      mem[pixel_count[AW-1:0]] <= '{black: black, px: img};
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- sv/mtws_back.sv -----
// back: averages, comparison scan over the stored window, threshold and result register
// depends on: mtws_pkg, mtws_divider
`default_nettype none

module mtws_back #(
  parameter int MAX_WINDOW_PIXELS = mtws_pkg::MAX_WINDOW_PIXELS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire mtws_pkg::q_status_t              q_stat,
  input  wire logic [2*mtws_pkg::COORD_W + 5*$clog2(MAX_WINDOW_PIXELS+1)
                     + 3*mtws_pkg::CH_W - 1:0]  q_data,
  output logic                                  q_pop,
  output logic [((MAX_WINDOW_PIXELS > 1) ? $clog2(MAX_WINDOW_PIXELS) : 1)-1:0] rd_addr,
  input  wire mtws_pkg::mem_word_t              rd_data,
  output logic                                  mem_release,
  input  wire logic [mtws_pkg::PCT_W-1:0]       pct,
  input  wire logic [mtws_pkg::TOL_W-1:0]       tol,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output mtws_pkg::result_t                     result
);

  localparam int CW  = $clog2(MAX_WINDOW_PIXELS + 1);
  localparam int SW  = CW + mtws_pkg::CH_W;
  localparam int AW  = (MAX_WINDOW_PIXELS > 1) ? $clog2(MAX_WINDOW_PIXELS) : 1;
  localparam int NWX = (CW + 1 > mtws_pkg::NET_W) ? CW + 1 : mtws_pkg::NET_W;
  localparam int TW  = CW + mtws_pkg::PCT_W;
  localparam int HW  = NWX + mtws_pkg::PCT_W;

  typedef enum logic [2:0] {B_IDLE, B_DIV, B_SCAN, B_CMP, B_FINAL} back_state_t;

  back_state_t                   state;
  logic [mtws_pkg::COORD_W-1:0]  q_row, q_col, job_row, job_col;
  logic [CW-1:0]                 q_pc, q_bc, job_pc, job_bc, issue_cnt;
  logic [SW-1:0]                 q_sr, q_sg, q_sb;
  logic [2:0][SW-1:0]            job_sums;
  logic                          div_start, div_done;
  logic [2:0][mtws_pkg::CH_W-1:0] div_q;
  logic [mtws_pkg::CH_W-1:0]     avg_r, avg_g, avg_b;
  logic                          nobg, rd_pend, issuing, hit;
  logic signed [NWX-1:0]         net;
  logic signed [HW-1:0]          net_ext, net100;
  logic [TW-1:0]                 thr;

  assign {q_row, q_col, q_pc, q_bc, q_sb, q_sg, q_sr} = q_data;

  function automatic logic near(input logic [7:0] avg, input logic [7:0] px,
                                input logic [7:0] t);
    logic [8:0] diff;
    logic [8:0] gap;
    diff = {1'b0, px} - {1'b0, avg};
    gap = diff[8] ? (~diff + 9'd1) : diff;
    return gap < {1'b0, t};
  endfunction

  assign q_pop   = (state == B_IDLE) && !q_stat.empty;
  assign issuing = (state == B_SCAN) && (issue_cnt != job_pc);
  assign rd_addr = issue_cnt[AW-1:0];

  // strict window on all three channels, inverted for foreground mask pixels
  always_comb begin
    hit = near(avg_r, rd_data.px.red, tol) && near(avg_g, rd_data.px.green, tol) &&
          near(avg_b, rd_data.px.blue, tol);
    if (!rd_data.black) begin
      hit = !hit;
    end
  end

  assign net_ext = {{mtws_pkg::PCT_W{net[NWX-1]}}, net};

  mtws_divider #(
    .MAX_WINDOW_PIXELS(MAX_WINDOW_PIXELS)
  ) u_divider (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .sums   (job_sums),
    .divisor(job_bc),
    .done   (div_done),
    .quot   (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      div_start   <= 1'b0;
      mem_release <= 1'b0;
      rd_pend     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      div_start   <= (state == B_IDLE) && !q_stat.empty && (q_bc != '0);
      // no background: nothing to scan, hand the memory straight back
      mem_release <= ((state == B_IDLE) && !q_stat.empty && (q_bc == '0)) ||
                     ((state == B_SCAN) && !issuing && !rd_pend);
      // the final step always leaves a word in the output register
      out_valid   <= (state == B_FINAL) || (out_valid && !out_ready);
      unique case (state)
        B_IDLE: begin
          if (!q_stat.empty) begin
            job_row   <= q_row;
            job_col   <= q_col;
            job_pc    <= q_pc;
            job_bc    <= q_bc;
            job_sums  <= {q_sb, q_sg, q_sr};
            nobg      <= (q_bc == '0);
            net       <= '0;
            issue_cnt <= '0;
            rd_pend   <= 1'b0;
            thr       <= {{mtws_pkg::PCT_W{1'b0}}, q_pc} * {{CW{1'b0}}, pct};
            if (q_bc == '0) begin
              avg_r <= '0;
              avg_g <= '0;
              avg_b <= '0;
              state <= B_CMP;
            end else begin
              state <= B_DIV;
            end
          end
        end
        B_DIV: begin
          if (div_done) begin
            avg_r <= div_q[0];
            avg_g <= div_q[1];
            avg_b <= div_q[2];
            state <= B_SCAN;
          end
        end
        B_SCAN: begin
          issue_cnt <= issue_cnt + CW'(issuing);
          rd_pend   <= issuing;
          if (rd_pend) begin
            net <= hit ? net + NWX'(1) : net - NWX'(1);
          end
          if (!issuing && !rd_pend) begin
            state <= B_CMP;
          end
        end
        // net > floor(count*pct/100) is the same as 100*net > count*pct
        B_CMP: begin
          net100 <= (net_ext <<< 6) + (net_ext <<< 5) + (net_ext <<< 2);
          state  <= B_FINAL;
        end
        B_FINAL: begin
          if (!out_valid || out_ready) begin
            result.is_match         <= !nobg &&
                                       (net100 > $signed({{(HW-TW){1'b0}}, thr}));
            result.net_score        <= net[mtws_pkg::NET_W-1:0];
            result.avg_red          <= avg_r;
            result.avg_green        <= avg_g;
            result.avg_blue         <= avg_b;
            result.no_background    <= nobg;
            result.match_row        <= job_row;
            result.match_col        <= job_col;
            state                   <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/mtws_checker.sv -----
// port-level checker of the window scorer, bound to the top level
// depends on: mtws_pkg, masked_template_window_score_macros.svh
`default_nettype none
`include "masked_template_window_score_macros.svh"

module mtws_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic                              s_axis_tlast,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [mtws_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

  // a stalled result word holds
  `MTWS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

  // the pixel memory is busy with the scan right after a window closes
  `MTWS_ASSERT_NEXT(a_wait_after_last, s_axis_tvalid && s_axis_tready && s_axis_tlast,
    !s_axis_tready, "input taken while the window is being scored")

  // no background: no match, zero score and zero averages
  `MTWS_ASSERT_SAME(a_nobg_zero, m_axis_tvalid && m_axis_tdata[39],
    m_axis_tdata[38:0] == 39'd0, "no-background result carries data")

  // a match needs a positive net score
  `MTWS_ASSERT_SAME(a_match_positive, m_axis_tvalid && m_axis_tdata[0],
    !m_axis_tdata[14] && (m_axis_tdata[14:1] != 14'd0), "match with non-positive score")

endmodule

bind masked_template_window_score mtws_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
